// ===== src/lage_pkg.sv =====
// Shared constants and types for the life grid engine.
package lage_pkg;

    // Field widths of the command and configuration channels.
    localparam int COORD_W    = 5;
    localparam int OP_W       = 2;
    localparam int SIDE_CFG_W = 6;

    // Default grid storage and the side in use after reset.
    localparam int                    GRID_DIM_DEFAULT = 32;
    localparam logic [SIDE_CFG_W-1:0] SIDE_RESET       = 6'd30;

    // Command codes.
    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_STEP  = 2'd2;

    // Neighbor counts of the B3/S23 rule.
    localparam logic [3:0] LIVE_KEEP = 4'd2;
    localparam logic [3:0] LIVE_BORN = 4'd3;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MODIFY,
        ST_GEN,
        ST_REPLY
    } state_t;

    // Control of the three-row window.
    typedef struct packed {
        logic clear;
        logic shift;
    } win_ctrl_t;

endpackage

// ===== src/lage_cmd_if.sv =====
// Command channel: one cell access or one generation step per transfer.
interface lage_cmd_if;
    import lage_pkg::*;

    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    op;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] column;
    logic               alive_in;

    modport source (output valid, output op, output row, output column, output alive_in,
                    input ready);
    modport sink (input valid, input op, input row, input column, input alive_in,
                  output ready);
endinterface

// ===== src/lage_result_if.sv =====
// Result channel: one result per accepted command.
interface lage_result_if;
    logic valid;
    logic ready;
    logic cell_value;
    logic bad_coordinate;

    modport source (output valid, output cell_value, output bad_coordinate, input ready);
    modport sink (input valid, input cell_value, input bad_coordinate, output ready);
endinterface

// ===== src/life_automaton_grid_engine_unit.sv =====
// Top level of the life grid engine: command sequencer, side register and result register.
// The engine holds a GRID_DIM by GRID_DIM grid of cells, all dead after reset, and takes one
// command at a time. A cell write or read goes through the transfer, one row fetch from the row
// memory and the result. A generation step sweeps the rows: the row memory has a single read
// port, so the sweep fetches one row word per cycle into a three-row window and writes each
// new row behind the fetch. The grid side in use is 1 to GRID_DIM (zero counts as 1, larger
// values saturate); cells outside it count as dead neighbors and keep their value. Per-row
// valid bits replace a clearing pass, so commands are taken right after reset. The side
// register must be written only while no command is in progress; the block itself does not
// enforce this.
module life_automaton_grid_engine_unit #(
    parameter int GRID_DIM = lage_pkg::GRID_DIM_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    lage_cmd_if.sink                          cmd,
    lage_result_if.source                     result,
    input  logic                              cfg_wr_en,
    input  logic [lage_pkg::SIDE_CFG_W-1:0]   cfg_wr_data
);
    import lage_pkg::*;

    localparam int ROW_W  = $clog2(GRID_DIM);
    localparam int STEP_W = $clog2(GRID_DIM + 2);
    localparam int CMP_W  = (STEP_W > SIDE_CFG_W) ? STEP_W : SIDE_CFG_W;

    state_t              state_reg, state_next;
    logic [SIDE_CFG_W-1:0] side_cfg_reg;
    logic [CMP_W-1:0]    cfg_ext, side_cmp, step_cmp, in_row_cmp, in_col_cmp;
    logic [STEP_W-1:0]   step_reg;
    logic [STEP_W-1:0]   gen_wr_step;
    logic [OP_W-1:0]     op_reg;
    logic [ROW_W-1:0]    row_reg, col_reg;
    logic                alive_reg, bad_reg, value_reg;
    logic                rd_issued_reg;
    logic                out_valid_reg, out_value_reg, out_bad_reg;
    logic                in_bad, in_access, accept, out_free, out_load;
    logic                rd_en, wr_en;
    logic [ROW_W-1:0]    rd_addr, wr_addr;
    logic [GRID_DIM-1:0] rd_row, wr_row, mod_row, gen_row, below_row, col_mask;
    win_ctrl_t           win_ctrl;

    // Side in use: zero counts as one, values beyond the storage saturate.
    assign cfg_ext  = CMP_W'(side_cfg_reg);
    assign side_cmp = (cfg_ext == '0) ? CMP_W'(1)
                    : (cfg_ext > CMP_W'(GRID_DIM)) ? CMP_W'(GRID_DIM) : cfg_ext;

    // Column mask of the grid in use.
    always_comb
    begin
        for (int c = 0; c < GRID_DIM; c++)
        begin
            col_mask[c] = (CMP_W'(c) < side_cmp);
        end
    end

    // Coordinate check of the incoming command.
    assign in_row_cmp = CMP_W'(cmd.row);
    assign in_col_cmp = CMP_W'(cmd.column);
    assign in_bad     = (in_row_cmp >= side_cmp) || (in_col_cmp >= side_cmp);
    assign in_access  = (cmd.op == OP_WRITE) || (cmd.op == OP_READ);
    assign accept     = cmd.valid && cmd.ready;

    assign step_cmp    = CMP_W'(step_reg);
    assign gen_wr_step = step_reg - STEP_W'(2);
    assign out_free    = !out_valid_reg || result.ready;

    // Single-cell update of the fetched row.
    always_comb
    begin
        mod_row          = rd_row;
        mod_row[col_reg] = alive_reg;
    end

    // Sequencer state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and memory, window and result control.
    always_comb
    begin
        state_next     = state_reg;
        cmd.ready      = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = step_reg[ROW_W-1:0];
        wr_en          = 1'b0;
        wr_addr        = gen_wr_step[ROW_W-1:0];
        wr_row         = gen_row;
        win_ctrl.clear = 1'b0;
        win_ctrl.shift = 1'b0;
        out_load       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.ready = 1'b1;
                if (cmd.valid)
                begin
                    if (in_access && !in_bad)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = in_row_cmp[ROW_W-1:0];
                        state_next = ST_MODIFY;
                    end
                    else if (cmd.op == OP_STEP)
                    begin
                        win_ctrl.clear = 1'b1;
                        state_next     = ST_GEN;
                    end
                    else
                    begin
                        state_next = ST_REPLY;
                    end
                end
            end
            ST_MODIFY:
            begin
                if (op_reg == OP_WRITE)
                begin
                    wr_en   = 1'b1;
                    wr_addr = row_reg;
                    wr_row  = mod_row;
                end
                state_next = ST_REPLY;
            end
            ST_GEN:
            begin
                win_ctrl.shift = 1'b1;
                if (step_cmp < side_cmp)
                begin
                    rd_en = 1'b1;
                end
                if (step_reg >= STEP_W'(2))
                begin
                    wr_en = 1'b1;
                end
                if (step_cmp == side_cmp + CMP_W'(1))
                begin
                    state_next = ST_REPLY;
                end
            end
            ST_REPLY:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers: side, sweep step, read tracking and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_cfg_reg  <= SIDE_RESET;
            step_reg      <= '0;
            rd_issued_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                side_cfg_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                step_reg <= '0;
            end
            else if (state_reg == ST_GEN)
            begin
                step_reg <= step_reg + STEP_W'(1);
            end
            rd_issued_reg <= rd_en;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Command payload and result fields.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= cmd.op;
            row_reg   <= in_row_cmp[ROW_W-1:0];
            col_reg   <= in_col_cmp[ROW_W-1:0];
            alive_reg <= cmd.alive_in;
            bad_reg   <= in_access && in_bad;
            value_reg <= 1'b0;
        end
        else if ((state_reg == ST_MODIFY) && (op_reg == OP_READ))
        begin
            value_reg <= rd_row[col_reg];
        end
        if (out_load)
        begin
            out_value_reg <= value_reg;
            out_bad_reg   <= bad_reg;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.cell_value     = out_value_reg;
    assign result.bad_coordinate = out_bad_reg;

    // Rows past the last one fetched enter the window as dead.
    assign below_row = rd_issued_reg ? rd_row : '0;

    lage_row_store #(
        .GRID_DIM (GRID_DIM)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_row  (wr_row),
        .rd_row  (rd_row)
    );

    lage_gen_window #(
        .GRID_DIM (GRID_DIM)
    ) u_window (
        .clk       (clk),
        .ctrl      (win_ctrl),
        .below_row (below_row),
        .col_mask  (col_mask),
        .new_row   (gen_row)
    );

endmodule

// ===== src/lage_row_store.sv =====
// Row memory of the grid with per-row valid bits so reset reads as all dead.
module lage_row_store #(
    parameter int GRID_DIM = lage_pkg::GRID_DIM_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        rd_en,
    input  logic [$clog2(GRID_DIM)-1:0] rd_addr,
    input  logic                        wr_en,
    input  logic [$clog2(GRID_DIM)-1:0] wr_addr,
    input  logic [GRID_DIM-1:0]         wr_row,
    output logic [GRID_DIM-1:0]         rd_row
);
    import lage_pkg::*;

    logic [GRID_DIM-1:0] mem [GRID_DIM];
    logic [GRID_DIM-1:0] row_valid_reg;
    logic [GRID_DIM-1:0] rd_data_reg;
    logic                rd_valid_reg;

    // Memory write and registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_row;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // A row never written since reset reads as all dead.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= row_valid_reg[rd_addr];
            end
        end
    end

    assign rd_row = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ===== src/lage_gen_window.sv =====
// Three-row window that row words shift through, with the life rule on the middle row.
module lage_gen_window #(
    parameter int GRID_DIM = lage_pkg::GRID_DIM_DEFAULT
) (
    input  logic                      clk,
    input  lage_pkg::win_ctrl_t       ctrl,
    input  logic [GRID_DIM-1:0]       below_row,
    input  logic [GRID_DIM-1:0]       col_mask,
    output logic [GRID_DIM-1:0]       new_row
);
    import lage_pkg::*;

    logic [GRID_DIM-1:0] up_reg;
    logic [GRID_DIM-1:0] mid_reg;
    logic [GRID_DIM-1:0] m_up, m_mid, m_below;
    logic [GRID_DIM-1:0] up_l, up_r, mid_l, mid_r, below_l, below_r;
    logic [3:0]          cnt [GRID_DIM];

    // Row words move up by one position per sweep step.
    always_ff @(posedge clk)
    begin
        if (ctrl.clear)
        begin
            up_reg  <= '0;
            mid_reg <= '0;
        end
        else if (ctrl.shift)
        begin
            up_reg  <= mid_reg;
            mid_reg <= below_row;
        end
    end

    // Columns outside the grid in use count as dead.
    assign m_up    = up_reg & col_mask;
    assign m_mid   = mid_reg & col_mask;
    assign m_below = below_row & col_mask;

    // Bit c of the left and right views holds the neighbor at column c-1 and c+1.
    assign up_l    = {m_up[GRID_DIM-2:0], 1'b0};
    assign up_r    = {1'b0, m_up[GRID_DIM-1:1]};
    assign mid_l   = {m_mid[GRID_DIM-2:0], 1'b0};
    assign mid_r   = {1'b0, m_mid[GRID_DIM-1:1]};
    assign below_l = {m_below[GRID_DIM-2:0], 1'b0};
    assign below_r = {1'b0, m_below[GRID_DIM-1:1]};

    // Neighbor count and rule for every column; columns outside the grid keep their value.
    always_comb
    begin
        for (int c = 0; c < GRID_DIM; c++)
        begin
            cnt[c] = 4'(up_l[c]) + 4'(m_up[c]) + 4'(up_r[c])
                   + 4'(mid_l[c]) + 4'(mid_r[c])
                   + 4'(below_l[c]) + 4'(m_below[c]) + 4'(below_r[c]);
            if (col_mask[c])
            begin
                new_row[c] = (cnt[c] == LIVE_BORN) || ((cnt[c] == LIVE_KEEP) && m_mid[c]);
            end
            else
            begin
                new_row[c] = mid_reg[c];
            end
        end
    end

endmodule
